// ----- design/srib_pkg.sv -----
// Package for the sorted record insertion buffer.
// Holds the item structs, the stored entry type, the cell control struct and the ordering function.
// No dependencies.
package srib_pkg;

  localparam int unsigned GradeW = 16;
  localparam int unsigned SidW   = 30;
  localparam int unsigned TagW   = 16;

  localparam logic OpInsert = 1'b0;
  localparam logic OpFlush  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [GradeW-1:0] grade;
    logic [SidW-1:0]   student_id;
    logic [TagW-1:0]   record_tag;
  } in_item_t;

  typedef struct packed {
    logic [GradeW-1:0] out_grade;
    logic [SidW-1:0]   out_student_id;
    logic [TagW-1:0]   out_tag;
    logic              last;
    logic              empty_res;
    logic              overflow;
  } out_item_t;

  typedef struct packed {
    logic [GradeW-1:0] grade;
    logic [SidW-1:0]   student_id;
    logic [TagW-1:0]   tag;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic shift_out;
  } cell_ctrl_t;

  // True if record a must be stored strictly ahead of record b.
  function automatic logic goes_before(entry_t a, entry_t b);
    logic res;
    if (a.grade != b.grade) begin
      res = (a.grade > b.grade);
    end else begin
      res = (a.student_id > b.student_id);
    end
    return res;
  endfunction

endpackage

// ----- design/sorted_record_insertion_buffer_top.sv -----
// Top level of the sorted record insertion buffer.
// Instantiates the chain of srib_cell cells and holds the count, flags and result registers.
// Depends on srib_pkg and srib_cell.

// An insert is accepted and every cell compares at once, so inserts can
// follow back to back. A flush of stored records keeps busy high while
// the chain shifts toward cell zero one entry a cycle; results appear one per cycle,
// the first in the cycle after busy rises, and cannot be held off. A flush of an
// empty store gives one item marked empty the next cycle and does not raise busy.
module sorted_record_insertion_buffer_top import srib_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            dropped_q, dropped_d;
  logic            flushing_q, flushing_d;
  logic            res_valid_q, res_valid_d;
  out_item_t       res_q, res_d;

  cell_ctrl_t ctrl;
  entry_t     new_entry;
  entry_t     entries [DEPTH];
  logic       ins     [DEPTH];
  logic       accept;
  logic       full;

  assign accept = start && !flushing_q;
  assign full   = (count_q == CntW'(DEPTH));

  assign new_entry.grade      = item_i.grade;
  assign new_entry.student_id = item_i.student_id;
  assign new_entry.tag        = item_i.record_tag;

  assign ctrl.insert    = accept && (item_i.op == OpInsert) && !full;
  assign ctrl.shift_out = flushing_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   prev_ins;
    entry_t prev_entry;
    entry_t next_entry;

    if (i == 0) begin : g_first
      assign prev_ins   = 1'b0;
      assign prev_entry = new_entry;
    end else begin : g_mid
      assign prev_ins   = ins[i-1];
      assign prev_entry = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign next_entry = '0;
    end else begin : g_inner
      assign next_entry = entries[i+1];
    end

    srib_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .new_entry_i  (new_entry),
      .occupied_i   (CntW'(i) < count_q),
      .prev_ins_i   (prev_ins),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .ins_o        (ins[i]),
      .entry_o      (entries[i])
    );
  end

  always_comb begin
    count_d     = count_q;
    dropped_d   = dropped_q;
    flushing_d  = flushing_q;
    res_valid_d = 1'b0;
    res_d       = res_q;

    if (flushing_q) begin
      res_valid_d          = 1'b1;
      res_d.out_grade      = entries[0].grade;
      res_d.out_student_id = entries[0].student_id;
      res_d.out_tag        = entries[0].tag;
      res_d.last           = (count_q == CntW'(1));
      res_d.empty_res      = 1'b0;
      res_d.overflow       = dropped_q;
      count_d              = count_q - CntW'(1);
      if (count_q == CntW'(1)) begin
        flushing_d = 1'b0;
        dropped_d  = 1'b0;
      end
    end else if (accept) begin
      if (item_i.op == OpInsert) begin
        if (full) begin
          dropped_d = 1'b1;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end else if (count_q == '0) begin
        res_valid_d = 1'b1;
        res_d       = '0;
        res_d.last      = 1'b1;
        res_d.empty_res = 1'b1;
        res_d.overflow  = dropped_q;
        dropped_d   = 1'b0;
      end else begin
        flushing_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dropped_q   <= 1'b0;
      flushing_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      flushing_q  <= flushing_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy        = flushing_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- design/srib_cell.sv -----
// One cell of the sorted insertion chain.
// Holds one entry, compares it with the broadcast record and trades with its neighbors.
// Depends on srib_pkg.
module srib_cell import srib_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     new_entry_i,
  input  logic       occupied_i,
  input  logic       prev_ins_i,
  input  entry_t     prev_entry_i,
  input  entry_t     next_entry_i,
  output logic       ins_o,
  output entry_t     entry_o
);

  entry_t entry_q, entry_d;

  // The new record belongs here or further up when the cell is free or holds a later record.
  assign ins_o = !occupied_i || goes_before(new_entry_i, entry_q);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_out) begin
      entry_d = next_entry_i;
    end else if (ctrl_i.insert) begin
      if (prev_ins_i) begin
        entry_d = prev_entry_i;
      end else if (ins_o) begin
        entry_d = new_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
